### sv/rrts_pkg.sv
package rrts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_W        = 5;
    localparam int HEAD_W      = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_CREATE = 3'd1;
    localparam logic [2:0] OP_EXIT   = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_JOIN   = 3'd4;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_WAIT    = 3'd2;
    localparam logic [2:0] ST_HALT    = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [1:0] TS_ABSENT    = 2'd0;
    localparam logic [1:0] TS_RUNNING   = 2'd1;
    localparam logic [1:0] TS_CANCELLED = 2'd2;
    localparam logic [1:0] TS_DONE      = 2'd3;

    typedef struct packed {
        logic            we_state;
        logic            we_mark;
        logic [ID_W-1:0] addr;
        logic [1:0]      state;
        logic [ID_W-1:0] mark;
    } t_tbl_wr;

    typedef struct packed {
        logic            pop;
        logic            push;
        logic [ID_W-1:0] push_id;
    } t_fifo_ctl;

endpackage

### sv/rrts_table.sv
module rrts_table import rrts_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_tbl_wr         i_wr,
    input  logic [ID_W-1:0] i_rd_addr,
    output logic [1:0]      o_rd_state,
    output logic [ID_W-1:0] o_rd_mark
);

    logic [1:0]      r_state [0:MAX_THREADS];
    logic [ID_W-1:0] r_mark  [0:MAX_THREADS];

    logic w_wr_ok;
    logic w_rd_ok;

    assign w_wr_ok = (i_wr.addr <= ID_W'(MAX_THREADS));
    assign w_rd_ok = (i_rd_addr <= ID_W'(MAX_THREADS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= MAX_THREADS; i++) begin
                r_state[i] <= (i == 1) ? TS_RUNNING : TS_ABSENT;
                r_mark[i]  <= '0;
            end
        end else if (w_wr_ok) begin
            if (i_wr.we_state) begin
                r_state[i_wr.addr] <= i_wr.state;
            end
            if (i_wr.we_mark) begin
                r_mark[i_wr.addr] <= i_wr.mark;
            end
        end
    end

    assign o_rd_state = w_rd_ok ? r_state[i_rd_addr] : TS_ABSENT;
    assign o_rd_mark  = w_rd_ok ? r_mark[i_rd_addr] : '0;

endmodule

### sv/rrts_fifo.sv
module rrts_fifo import rrts_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_fifo_ctl        i_ctl,
    output logic [ID_W-1:0]  o_head_id,
    output logic [CNT_W-1:0] o_count
);

    logic [ID_W-1:0]   r_q [0:MAX_THREADS-1];
    logic [HEAD_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W:0]    w_sum;
    logic [CNT_W:0]    w_tail;
    logic              w_push_ok;

    assign w_sum     = {1'b0, r_count} + (CNT_W+1)'(r_head);
    assign w_tail    = (w_sum >= (CNT_W+1)'(MAX_THREADS)) ?
                       w_sum - (CNT_W+1)'(MAX_THREADS) : w_sum;
    assign w_push_ok = i_ctl.push && (r_count < CNT_W'(MAX_THREADS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_ctl.pop) begin
            r_head  <= (r_head == HEAD_W'(MAX_THREADS - 1)) ? '0 : r_head + 1'b1;
            r_count <= r_count - 1'b1;
        end else if (w_push_ok) begin
            r_count <= r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok && !i_ctl.pop) begin
            r_q[w_tail[HEAD_W-1:0]] <= i_ctl.push_id;
        end
    end

    assign o_head_id = r_q[r_head];
    assign o_count   = r_count;

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> r_count != '0)
        else $error("pop from empty ready queue");

    a_pop_push_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.pop && i_ctl.push))
        else $error("pop and push in the same cycle");

endmodule

### sv/round_robin_thread_scheduler.sv
// Round-robin thread scheduler.
// Request channel: i_operation and i_target_thread are taken at a rising edge
// where start is high and busy is low. busy stays high while the request is
// processed; no new request is taken meanwhile.
// Result channel: o_valid is high for exactly one cycle with o_running_thread,
// o_new_thread, o_status and o_target_state. The receiver cannot stall; the
// result is gone after that cycle. busy is already low in the o_valid cycle.
// Flow: create, cancel of another thread, join and unknown codes are decided
// in S_DEC, whose result is registered to the outputs. Tick, exit and cancel
// of the running thread go on to S_POP, which pops the ready queue one entry
// per cycle through the shared state table read port, skipping cancelled ids,
// until a live id is found or the queue is empty; S_FIN then gives the result.
// One request is in flight at a time; a new one is taken only while busy is low.
// Reset (i_rst_n low, synchronous): queue empty, every id absent but main
// thread 1, which is running, next free id 2, no result pending.
module round_robin_thread_scheduler import rrts_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic [2:0]      i_operation,
    input  logic [4:0]      i_target_thread,
    output logic            o_valid,
    output logic [4:0]      o_running_thread,
    output logic [4:0]      o_new_thread,
    output logic [2:0]      o_status,
    output logic [1:0]      o_target_state
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]      r_state, n_state;
    logic [2:0]      r_op;
    logic [ID_W-1:0] r_tgt;
    logic            r_exit, n_exit;
    logic [ID_W-1:0] r_next, n_next;
    logic [ID_W-1:0] r_running, n_running;
    logic [ID_W-1:0] r_next_free, n_next_free;

    logic            r_o_valid, n_o_valid;
    logic [ID_W-1:0] r_o_running, n_o_running;
    logic [ID_W-1:0] r_o_new, n_o_new;
    logic [2:0]      r_o_status, n_o_status;
    logic [1:0]      r_o_tstate, n_o_tstate;

    t_tbl_wr          w_tbl_wr;
    t_fifo_ctl        w_fifo_ctl;
    logic [ID_W-1:0]  w_rd_addr;
    logic [1:0]       w_rd_state;
    logic [ID_W-1:0]  w_rd_mark;
    logic [ID_W-1:0]  w_head_id;
    logic [CNT_W-1:0] w_count;
    logic             w_in_range;
    logic [1:0]       w_tstate;
    logic             w_head_live;

    rrts_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_tbl_wr),
        .i_rd_addr  (w_rd_addr),
        .o_rd_state (w_rd_state),
        .o_rd_mark  (w_rd_mark)
    );

    rrts_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_fifo_ctl),
        .o_head_id (w_head_id),
        .o_count   (w_count)
    );

    assign busy       = (r_state != S_IDLE);
    assign w_rd_addr  = (r_state == S_POP) ? w_head_id : r_tgt;
    assign w_in_range = (r_tgt != '0) && (r_tgt <= ID_W'(MAX_THREADS));
    assign w_tstate   = w_in_range ? w_rd_state : TS_ABSENT;
    assign w_head_live = (w_head_id != '0) && (w_head_id <= ID_W'(MAX_THREADS)) &&
                         (w_rd_state == TS_RUNNING);

    always_comb begin
        n_state     = r_state;
        n_exit      = r_exit;
        n_next      = r_next;
        n_running   = r_running;
        n_next_free = r_next_free;
        n_o_valid   = 1'b0;
        n_o_running = r_o_running;
        n_o_new     = r_o_new;
        n_o_status  = r_o_status;
        n_o_tstate  = r_o_tstate;
        w_tbl_wr    = '0;
        w_fifo_ctl  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state     = S_IDLE;
                n_o_valid   = 1'b1;
                n_o_running = r_running;
                n_o_new     = '0;
                n_o_status  = ST_OK;
                n_o_tstate  = TS_ABSENT;
                unique case (r_op)
                    OP_TICK: begin
                        n_exit    = 1'b0;
                        n_state   = S_POP;
                        n_o_valid = 1'b0;
                    end
                    OP_CREATE: begin
                        if (r_next_free > ID_W'(MAX_THREADS) ||
                            w_count >= CNT_W'(MAX_THREADS)) begin
                            n_o_status = ST_FULL;
                        end else begin
                            n_o_new            = r_next_free;
                            n_next_free        = r_next_free + 1'b1;
                            w_tbl_wr.we_state  = 1'b1;
                            w_tbl_wr.we_mark   = 1'b1;
                            w_tbl_wr.addr      = r_next_free;
                            w_tbl_wr.state     = TS_RUNNING;
                            w_fifo_ctl.push    = 1'b1;
                            w_fifo_ctl.push_id = r_next_free;
                        end
                    end
                    OP_EXIT: begin
                        n_exit    = 1'b1;
                        n_state   = S_POP;
                        n_o_valid = 1'b0;
                    end
                    OP_CANCEL: begin
                        if (r_tgt == r_running) begin
                            n_exit    = 1'b1;
                            n_state   = S_POP;
                            n_o_valid = 1'b0;
                        end else if (!w_in_range || w_rd_state != TS_RUNNING) begin
                            n_o_status = ST_INVALID;
                        end else begin
                            w_tbl_wr.we_state = 1'b1;
                            w_tbl_wr.we_mark  = 1'b1;
                            w_tbl_wr.addr     = r_tgt;
                            w_tbl_wr.state    = TS_CANCELLED;
                        end
                    end
                    OP_JOIN: begin
                        n_o_tstate = w_tstate;
                        if (r_tgt == r_running || !w_in_range || w_tstate == TS_ABSENT ||
                            w_rd_mark == r_running) begin
                            n_o_status = ST_INVALID;
                        end else begin
                            w_tbl_wr.we_mark = 1'b1;
                            w_tbl_wr.addr    = r_running;
                            w_tbl_wr.mark    = r_tgt;
                            n_o_status = (w_tstate == TS_RUNNING) ? ST_WAIT : ST_OK;
                        end
                    end
                    default: begin
                        n_o_status = ST_INVALID;
                    end
                endcase
            end
            S_POP: begin
                if (w_count == '0) begin
                    n_next  = '0;
                    n_state = S_FIN;
                end else begin
                    w_fifo_ctl.pop = 1'b1;
                    if (w_head_live) begin
                        n_next  = w_head_id;
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                n_state    = S_IDLE;
                n_o_valid  = 1'b1;
                n_o_new    = '0;
                n_o_tstate = TS_ABSENT;
                n_o_status = ST_OK;
                if (r_next == '0) begin
                    n_o_status = r_exit ? ST_HALT : ST_OK;
                end else if (!r_exit || r_running == ID_W'(1)) begin
                    w_fifo_ctl.push    = 1'b1;
                    w_fifo_ctl.push_id = r_running;
                    n_running          = r_next;
                    n_o_status         = r_exit ? ST_WAIT : ST_OK;
                end else begin
                    w_tbl_wr.we_state = 1'b1;
                    w_tbl_wr.we_mark  = 1'b1;
                    w_tbl_wr.addr     = r_running;
                    w_tbl_wr.state    = TS_DONE;
                    n_running         = r_next;
                end
                n_o_running = n_running;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_exit      <= 1'b0;
            r_next      <= '0;
            r_running   <= ID_W'(1);
            r_next_free <= ID_W'(2);
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_exit      <= n_exit;
            r_next      <= n_next;
            r_running   <= n_running;
            r_next_free <= n_next_free;
            r_o_valid   <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_op  <= i_operation;
            r_tgt <= i_target_thread;
        end
        r_o_running <= n_o_running;
        r_o_new     <= n_o_new;
        r_o_status  <= n_o_status;
        r_o_tstate  <= n_o_tstate;
    end

    assign o_valid          = r_o_valid;
    assign o_running_thread = r_o_running;
    assign o_new_thread     = r_o_new;
    assign o_status         = r_o_status;
    assign o_target_state   = r_o_tstate;

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> r_state == S_IDLE)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("request finished without a result");

    a_running_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running != '0 && r_running <= ID_W'(MAX_THREADS))
        else $error("running id out of range");

endmodule
